### hdl/cgnc_pkg.sv
// Shared types and constants for the cell grid neighbour counter.
`timescale 1ns / 1ps

package cgnc_pkg;

  localparam int CFG_SIZE_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WALLS  = 2'd2;

  localparam logic [2:0] OP_TOGGLE = 3'd0;
  localparam logic [2:0] OP_SET    = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_FILL   = 3'd3;
  localparam logic [2:0] OP_COUNT  = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] col;
    logic [5:0] row;
    logic       new_alive;
  } in_item_t;

  typedef struct packed {
    logic       in_bounds;
    logic       cell_alive;
    logic [3:0] neighbour_count;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_SWEEP,
    KIND_WRITE,
    KIND_COUNT,
    KIND_PEEK
  } op_kind_t;

  typedef enum logic [1:0] {
    ROW_UP,
    ROW_MID,
    ROW_DN
  } row_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_RD_UP,
    ST_RD_MID,
    ST_RD_DN,
    ST_ACC,
    ST_MOD,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    row_sel_t rd_sel;
    logic     acc_en;
    row_sel_t acc_sel;
    logic     mid_now;
    logic     wr_row;
    logic     sweep_wr;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    op_kind_t kind;
    logic     inb;
    logic     sweep_last;
  } dp_status_t;

endpackage

### hdl/cgnc_ctrl.sv
// Sequencing state machine for the cell grid neighbour counter.
`timescale 1ns / 1ps

module cgnc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  cgnc_pkg::dp_status_t st,
  output cgnc_pkg::dp_cmd_t    cmd,
  output logic                busy
);

  cgnc_pkg::ctrl_state_t state_r, state_nxt;
  logic                  count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cgnc_pkg::ST_IDLE;
      count_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    cmd         = '0;
    cmd.rd_sel  = cgnc_pkg::ROW_MID;
    cmd.acc_sel = cgnc_pkg::ROW_MID;
    unique case (state_r)
      cgnc_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          count_nxt = (st.kind == cgnc_pkg::KIND_COUNT);
          priority if (st.kind == cgnc_pkg::KIND_SWEEP) begin
            state_nxt = cgnc_pkg::ST_SWEEP;
          end else if (!st.inb) begin
            state_nxt = cgnc_pkg::ST_DONE;
          end else if (st.kind == cgnc_pkg::KIND_COUNT) begin
            state_nxt = cgnc_pkg::ST_RD_UP;
          end else begin
            state_nxt = cgnc_pkg::ST_RD_MID;
          end
        end
      end
      cgnc_pkg::ST_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (st.sweep_last) begin
          cmd.finish = 1'b1;
          state_nxt  = cgnc_pkg::ST_IDLE;
        end
      end
      cgnc_pkg::ST_RD_UP: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = cgnc_pkg::ROW_UP;
        state_nxt  = cgnc_pkg::ST_RD_MID;
      end
      cgnc_pkg::ST_RD_MID: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = cgnc_pkg::ROW_MID;
        if (count_r) begin
          cmd.acc_en  = 1'b1;
          cmd.acc_sel = cgnc_pkg::ROW_UP;
          state_nxt   = cgnc_pkg::ST_RD_DN;
        end else begin
          state_nxt = cgnc_pkg::ST_MOD;
        end
      end
      cgnc_pkg::ST_RD_DN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = cgnc_pkg::ROW_DN;
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = cgnc_pkg::ROW_MID;
        cmd.mid_now = 1'b1;
        state_nxt   = cgnc_pkg::ST_ACC;
      end
      cgnc_pkg::ST_ACC: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = cgnc_pkg::ROW_DN;
        cmd.finish  = 1'b1;
        state_nxt   = cgnc_pkg::ST_IDLE;
      end
      cgnc_pkg::ST_MOD: begin
        cmd.mid_now = 1'b1;
        cmd.wr_row  = 1'b1;
        cmd.finish  = 1'b1;
        state_nxt   = cgnc_pkg::ST_IDLE;
      end
      cgnc_pkg::ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = cgnc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = cgnc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != cgnc_pkg::ST_IDLE);

endmodule

### hdl/cgnc_dp.sv
// Datapath of the cell grid neighbour counter: cell store, neighbour adder and result register.
`timescale 1ns / 1ps

module cgnc_dp #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cgnc_pkg::in_item_t                  in_data,
  input  logic [cgnc_pkg::CFG_SIZE_W-1:0]     grid_width,
  input  logic [cgnc_pkg::CFG_SIZE_W-1:0]     grid_height,
  input  logic                                walls_on,
  input  cgnc_pkg::dp_cmd_t                   cmd,
  output cgnc_pkg::dp_status_t                st,
  output logic                                out_strobe,
  output cgnc_pkg::out_item_t                 out_data
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int WW = ($clog2(MAX_COLS + 1) > cgnc_pkg::CFG_SIZE_W) ?
                      $clog2(MAX_COLS + 1) : cgnc_pkg::CFG_SIZE_W;
  localparam int HW = ($clog2(MAX_ROWS + 1) > cgnc_pkg::CFG_SIZE_W) ?
                      $clog2(MAX_ROWS + 1) : cgnc_pkg::CFG_SIZE_W;

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_vld_r;
  logic [MAX_COLS-1:0] rd_data_r;
  logic                rd_valid_r;

  logic [2:0]    op_r;
  logic [5:0]    col_r;
  logic [5:0]    row_r;
  logic          nv_r;
  logic          inb_r;
  logic          alive_r;
  logic [3:0]    cnt_r;
  logic [RW-1:0] sweep_r;
  logic          out_valid_r;
  cgnc_pkg::out_item_t out_data_r;

  logic [WW-1:0] w_eff, gw_x, col_x, c_lft_x, c_rgt_x;
  logic [HW-1:0] h_eff, gh_x, row_x, r_up_x, r_dn_x;
  logic          up_ok, dn_ok, lft_ok, rgt_ok;
  logic [RW-1:0] rd_addr, mid_addr;
  logic [CW-1:0] c_lft, c_mid, c_rgt;
  logic [MAX_COLS-1:0] rd_row, new_row, fill_row;
  logic          mid_bit_new, row_ok, bit_l, bit_c, bit_r;
  logic [1:0]    row_sum;
  logic [3:0]    cnt_sum;
  logic          alive_src;

  // Effective grid size: zero acts as one, anything above the store acts as its size.
  always_comb begin
    gw_x = WW'(grid_width);
    gh_x = HW'(grid_height);
    if (grid_width == '0) begin
      w_eff = WW'(1);
    end else if (gw_x > WW'(MAX_COLS)) begin
      w_eff = WW'(MAX_COLS);
    end else begin
      w_eff = gw_x;
    end
    if (grid_height == '0) begin
      h_eff = HW'(1);
    end else if (gh_x > HW'(MAX_ROWS)) begin
      h_eff = HW'(MAX_ROWS);
    end else begin
      h_eff = gh_x;
    end
  end

  always_comb begin
    st.inb        = (WW'(in_data.col) < w_eff) && (HW'(in_data.row) < h_eff);
    st.sweep_last = (sweep_r == RW'(MAX_ROWS - 1));
    unique case (in_data.op)
      cgnc_pkg::OP_CLEAR, cgnc_pkg::OP_FILL:  st.kind = cgnc_pkg::KIND_SWEEP;
      cgnc_pkg::OP_TOGGLE, cgnc_pkg::OP_SET:  st.kind = cgnc_pkg::KIND_WRITE;
      cgnc_pkg::OP_COUNT:                     st.kind = cgnc_pkg::KIND_COUNT;
      default:                                st.kind = cgnc_pkg::KIND_PEEK;
    endcase
  end

  // Neighbour coordinates, wrapped around the edges of the grid in use; with walls on, off-edge neighbours are masked.
  always_comb begin
    col_x   = WW'(col_r);
    row_x   = HW'(row_r);
    c_lft_x = (col_x == '0) ? w_eff - WW'(1) : col_x - WW'(1);
    c_rgt_x = (col_x + WW'(1) == w_eff) ? '0 : col_x + WW'(1);
    r_up_x  = (row_x == '0) ? h_eff - HW'(1) : row_x - HW'(1);
    r_dn_x  = (row_x + HW'(1) == h_eff) ? '0 : row_x + HW'(1);
    lft_ok  = !walls_on || (col_x != '0);
    rgt_ok  = !walls_on || (col_x + WW'(1) != w_eff);
    up_ok   = !walls_on || (row_x != '0);
    dn_ok   = !walls_on || (row_x + HW'(1) != h_eff);
    c_lft   = c_lft_x[CW-1:0];
    c_mid   = col_x[CW-1:0];
    c_rgt   = c_rgt_x[CW-1:0];
    mid_addr = row_x[RW-1:0];
    unique case (cmd.rd_sel)
      cgnc_pkg::ROW_UP: rd_addr = r_up_x[RW-1:0];
      cgnc_pkg::ROW_DN: rd_addr = r_dn_x[RW-1:0];
      default:          rd_addr = mid_addr;
    endcase
  end

  always_comb begin
    rd_row   = rd_valid_r ? rd_data_r : '0;
    fill_row = (op_r == cgnc_pkg::OP_FILL) ? '1 : '0;
    priority if (op_r == cgnc_pkg::OP_TOGGLE) begin
      mid_bit_new = ~rd_row[c_mid];
    end else if (op_r == cgnc_pkg::OP_SET) begin
      mid_bit_new = nv_r;
    end else begin
      mid_bit_new = rd_row[c_mid];
    end
    new_row        = rd_row;
    new_row[c_mid] = mid_bit_new;
  end

  always_comb begin
    bit_l = lft_ok && rd_row[c_lft];
    bit_c = (cmd.acc_sel != cgnc_pkg::ROW_MID) && rd_row[c_mid];
    bit_r = rgt_ok && rd_row[c_rgt];
    unique case (cmd.acc_sel)
      cgnc_pkg::ROW_UP: row_ok = up_ok;
      cgnc_pkg::ROW_DN: row_ok = dn_ok;
      default:          row_ok = 1'b1;
    endcase
    row_sum   = row_ok ? (2'(bit_l) + 2'(bit_c) + 2'(bit_r)) : 2'd0;
    cnt_sum   = cnt_r + 4'(row_sum);
    alive_src = cmd.mid_now ? mid_bit_new : alive_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_wr) begin
      mem[sweep_r] <= fill_row;
    end else if (cmd.wr_row) begin
      mem[mid_addr] <= new_row;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r  <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (cmd.sweep_wr) begin
        row_vld_r[sweep_r] <= 1'b1;
      end else if (cmd.wr_row) begin
        row_vld_r[mid_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_valid_r <= row_vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_data.op;
      col_r   <= in_data.col;
      row_r   <= in_data.row;
      nv_r    <= in_data.new_alive;
      inb_r   <= st.inb;
      alive_r <= (in_data.op == cgnc_pkg::OP_FILL);
      cnt_r   <= '0;
      sweep_r <= '0;
    end else begin
      if (cmd.sweep_wr) begin
        sweep_r <= sweep_r + RW'(1);
      end
      if (cmd.acc_en) begin
        cnt_r <= cnt_sum;
      end
      if (cmd.mid_now) begin
        alive_r <= mid_bit_new;
      end
    end
    if (cmd.finish) begin
      out_data_r.in_bounds       <= inb_r;
      out_data_r.cell_alive      <= inb_r & alive_src;
      out_data_r.neighbour_count <= cmd.acc_en ? cnt_sum : cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_data   = out_data_r;

endmodule

### hdl/cell_grid_neighbour_counter.sv
// Top level of the cell grid neighbour counter: configuration registers and block assembly.
`timescale 1ns / 1ps

// A command is taken at a rising edge with start high and busy low; busy then stays
// high until the command is done. Each command gives one result beat on out_data,
// marked by out_strobe for one cycle, in the cycle in which busy falls. The
// receiver cannot stall; a new command may be started in the same cycle the
// previous result is shown.
// A count reads three rows from the single-port cell store, one row per cycle;
// toggle, set and unused codes read the addressed row and write it back, a
// coordinate outside the grid skips the store, and clear or fill write every
// row of the store, one row per cycle.
// The cfg port writes grid_width (index 0), grid_height (index 1) and walls_on
// (index 2) at any edge with cfg_we high; change it only while busy is low.
// Synchronous reset returns the sizes to 64 by 64 with wrapping edges, marks every
// row of the store as dead through per-row valid bits at once, and drops any
// command in progress.

module cell_grid_neighbour_counter #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  cgnc_pkg::in_item_t                in_data,
  output logic                              out_strobe,
  output cgnc_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [cgnc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cgnc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [cgnc_pkg::CFG_SIZE_W-1:0] grid_width_r;
  logic [cgnc_pkg::CFG_SIZE_W-1:0] grid_height_r;
  logic                            walls_on_r;
  cgnc_pkg::dp_cmd_t               cmd;
  cgnc_pkg::dp_status_t            st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= cgnc_pkg::CFG_SIZE_W'(64);
      grid_height_r <= cgnc_pkg::CFG_SIZE_W'(64);
      walls_on_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cgnc_pkg::CFG_IDX_WIDTH:  grid_width_r  <= cfg_data;
        cgnc_pkg::CFG_IDX_HEIGHT: grid_height_r <= cfg_data;
        cgnc_pkg::CFG_IDX_WALLS:  walls_on_r    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  cgnc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  cgnc_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .walls_on    (walls_on_r),
    .cmd         (cmd),
    .st          (st),
    .out_strobe  (out_strobe),
    .out_data    (out_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted command did not raise busy.");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(busy) && !busy))
    else $error("Result beat without a command finishing.");

  a_alive_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.in_bounds) |->
      (!out_data.cell_alive && (out_data.neighbour_count == 4'd0)))
    else $error("Off-grid result reports a live cell or neighbours.");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.neighbour_count <= 4'd8))
    else $error("Neighbour count above eight.");

endmodule

### bench/cell_grid_neighbour_counter_tb.sv
// Self-checking testbench for the cell grid neighbour counter: directed table, then random phases.
`timescale 1ns / 1ps

module cell_grid_neighbour_counter_tb;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 100;

  typedef struct packed {
    logic [6:0]          grid_w;
    logic [6:0]          grid_h;
    logic                walls;
    cgnc_pkg::in_item_t  cmd;
    logic                typed;
    cgnc_pkg::out_item_t want;
  } probe_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  cgnc_pkg::in_item_t              in_data;
  logic                            out_strobe;
  cgnc_pkg::out_item_t             out_data;
  logic                            cfg_we;
  logic [cgnc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cgnc_pkg::CFG_DATA_W-1:0] cfg_data;

  logic [GRID_COLS-1:0] model_cells [GRID_ROWS];
  logic [6:0]           grid_w_reg;
  logic [6:0]           grid_h_reg;
  logic                 walls_reg;
  cgnc_pkg::out_item_t  due_cell_reports [$];
  probe_row_t           probe_rows [$];
  int                   mismatch_count;

  cell_grid_neighbour_counter #(
    .MAX_COLS(GRID_COLS),
    .MAX_ROWS(GRID_ROWS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int used_size(logic [6:0] v, int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic logic [3:0] live_neighbours(int c, int r, int w, int h);
    int cnt;
    int nr;
    int nc;
    cnt = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr == 0 && dc == 0) continue;
        nr = r + dr;
        nc = c + dc;
        if (walls_reg) begin
          if (nc < 0 || nc >= w || nr < 0 || nr >= h) continue;
        end else begin
          nc = ((nc % w) + w) % w;
          nr = ((nr % h) + h) % h;
        end
        if (model_cells[nr][nc]) cnt++;
      end
    end
    return cnt[3:0];
  endfunction

  function automatic cgnc_pkg::out_item_t apply_grid_cmd(cgnc_pkg::in_item_t cmd);
    int w;
    int h;
    cgnc_pkg::out_item_t res;
    w = used_size(grid_w_reg, GRID_COLS);
    h = used_size(grid_h_reg, GRID_ROWS);
    res = '0;
    if (cmd.op == cgnc_pkg::OP_CLEAR) begin
      for (int i = 0; i < GRID_ROWS; i++) model_cells[i] = '0;
    end else if (cmd.op == cgnc_pkg::OP_FILL) begin
      for (int i = 0; i < GRID_ROWS; i++) model_cells[i] = '1;
    end
    if (cmd.col < w && cmd.row < h) begin
      case (cmd.op)
        cgnc_pkg::OP_TOGGLE: model_cells[cmd.row][cmd.col] = ~model_cells[cmd.row][cmd.col];
        cgnc_pkg::OP_SET:    model_cells[cmd.row][cmd.col] = cmd.new_alive;
        cgnc_pkg::OP_COUNT:  res.neighbour_count = live_neighbours(cmd.col, cmd.row, w, h);
        default: ;
      endcase
      res.in_bounds = 1'b1;
      res.cell_alive = model_cells[cmd.row][cmd.col];
    end
    return res;
  endfunction

  function automatic cgnc_pkg::in_item_t random_cmd();
    cgnc_pkg::in_item_t cmd;
    int pick;
    int w;
    int h;
    w = used_size(grid_w_reg, GRID_COLS);
    h = used_size(grid_h_reg, GRID_ROWS);
    pick = $urandom_range(99);
    if (pick < 30) cmd.op = cgnc_pkg::OP_TOGGLE;
    else if (pick < 50) cmd.op = cgnc_pkg::OP_SET;
    else if (pick < 85) cmd.op = cgnc_pkg::OP_COUNT;
    else if (pick < 88) cmd.op = cgnc_pkg::OP_CLEAR;
    else if (pick < 91) cmd.op = cgnc_pkg::OP_FILL;
    else if (pick < 95) cmd.op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    else cmd.op = 3'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) begin
      cmd.col = 6'(($urandom_range(3) + 2 * w - 2) % w);
      cmd.row = 6'(($urandom_range(3) + 2 * h - 2) % h);
    end else if (pick < 85) begin
      cmd.col = 6'($urandom_range(w - 1));
      cmd.row = 6'($urandom_range(h - 1));
    end else begin
      cmd.col = 6'($urandom);
      cmd.row = 6'($urandom);
    end
    cmd.new_alive = 1'($urandom);
    return cmd;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic issue_cmd(input cgnc_pkg::in_item_t cmd, input logic typed,
                           input cgnc_pkg::out_item_t want);
    cgnc_pkg::out_item_t predicted;
    start <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_grid_cmd(cmd);
    due_cell_reports.push_back(typed ? want : predicted);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (due_cell_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_grid_regs(input logic [6:0] w, input logic [6:0] h, input logic walls);
    cfg_we <= 1'b1;
    cfg_index <= cgnc_pkg::CFG_IDX_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    grid_w_reg = w;
    cfg_index <= cgnc_pkg::CFG_IDX_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    grid_h_reg = h;
    cfg_index <= cgnc_pkg::CFG_IDX_WALLS;
    cfg_data <= {6'($urandom), walls};
    @(posedge clk);
    walls_reg = walls;
    cfg_we <= 1'b0;
  endtask

  task automatic add_probe(input logic [6:0] w, input logic [6:0] h, input logic walls,
                           input logic [2:0] op, input logic [5:0] col, input logic [5:0] row,
                           input logic nv, input logic typed, input logic ib,
                           input logic al, input logic [3:0] cnt);
    probe_row_t pr;
    pr.grid_w = w;
    pr.grid_h = h;
    pr.walls = walls;
    pr.cmd = '{op: op, col: col, row: row, new_alive: nv};
    pr.typed = typed;
    pr.want = '{in_bounds: ib, cell_alive: al, neighbour_count: cnt};
    probe_rows.push_back(pr);
  endtask

  always @(posedge clk) begin
    cgnc_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      if (due_cell_reports.size() == 0) begin
        report_mismatch("result beat with nothing pending", out_data, 0);
      end else begin
        want = due_cell_reports.pop_front();
        if (out_data.in_bounds !== want.in_bounds)
          report_mismatch("in_bounds", out_data.in_bounds, want.in_bounds);
        if (out_data.cell_alive !== want.cell_alive)
          report_mismatch("cell_alive", out_data.cell_alive, want.cell_alive);
        if (out_data.neighbour_count !== want.neighbour_count)
          report_mismatch("neighbour_count", out_data.neighbour_count, want.neighbour_count);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [6:0] w;
    logic [6:0] h;
    logic       walls;
    logic       idle_on;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = cgnc_pkg::CFG_IDX_WIDTH;
    cfg_data = '0;
    mismatch_count = 0;
    for (int i = 0; i < GRID_ROWS; i++) model_cells[i] = '0;
    grid_w_reg = 7'd64;
    grid_h_reg = 7'd64;
    walls_reg = 1'b0;

    add_probe(64, 64, 0, cgnc_pkg::OP_COUNT, 0, 0, 0, 1, 1, 0, 0);
    add_probe(64, 64, 0, cgnc_pkg::OP_TOGGLE, 0, 0, 0, 1, 1, 1, 0);
    add_probe(64, 64, 0, cgnc_pkg::OP_TOGGLE, 63, 63, 0, 1, 1, 1, 0);
    add_probe(64, 64, 0, cgnc_pkg::OP_COUNT, 0, 0, 0, 0, 0, 0, 0);
    add_probe(64, 64, 0, cgnc_pkg::OP_SET, 63, 0, 1, 1, 1, 1, 0);
    add_probe(64, 64, 0, cgnc_pkg::OP_SET, 63, 0, 0, 1, 1, 0, 0);
    add_probe(64, 64, 0, cgnc_pkg::OP_FILL, 42, 21, 0, 1, 1, 1, 0);
    add_probe(64, 64, 0, cgnc_pkg::OP_COUNT, 21, 42, 1, 1, 1, 1, 8);
    add_probe(64, 64, 0, OP_UNUSED_LO, 1, 1, 0, 1, 1, 1, 0);
    add_probe(64, 64, 0, OP_UNUSED_LO + 3'd1, 30, 33, 1, 1, 1, 1, 0);
    add_probe(64, 64, 0, OP_UNUSED_HI, 62, 62, 0, 1, 1, 1, 0);
    add_probe(64, 64, 0, cgnc_pkg::OP_CLEAR, 63, 63, 1, 1, 1, 0, 0);
    add_probe(64, 64, 0, cgnc_pkg::OP_SET, 1, 1, 1, 1, 1, 1, 0);
    add_probe(3, 2, 0, cgnc_pkg::OP_COUNT, 0, 0, 0, 0, 0, 0, 0);
    add_probe(3, 2, 0, cgnc_pkg::OP_TOGGLE, 3, 0, 0, 1, 0, 0, 0);
    add_probe(3, 2, 0, cgnc_pkg::OP_COUNT, 0, 2, 0, 1, 0, 0, 0);
    add_probe(3, 2, 0, cgnc_pkg::OP_SET, 63, 63, 1, 1, 0, 0, 0);
    add_probe(3, 2, 0, cgnc_pkg::OP_FILL, 10, 10, 0, 1, 0, 0, 0);
    add_probe(3, 2, 0, cgnc_pkg::OP_COUNT, 2, 1, 0, 0, 0, 0, 0);
    add_probe(1, 1, 1, cgnc_pkg::OP_COUNT, 0, 0, 0, 1, 1, 1, 0);
    add_probe(0, 127, 0, cgnc_pkg::OP_COUNT, 0, 5, 0, 0, 0, 0, 0);
    add_probe(0, 127, 0, cgnc_pkg::OP_TOGGLE, 1, 5, 0, 1, 0, 0, 0);
    add_probe(127, 0, 1, cgnc_pkg::OP_COUNT, 63, 0, 0, 0, 0, 0, 0);
    add_probe(127, 0, 1, cgnc_pkg::OP_CLEAR, 0, 1, 0, 1, 0, 0, 0);
    add_probe(64, 64, 1, cgnc_pkg::OP_COUNT, 0, 0, 0, 1, 1, 0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probe_rows[i]) begin
      if (probe_rows[i].grid_w != grid_w_reg || probe_rows[i].grid_h != grid_h_reg ||
          probe_rows[i].walls != walls_reg) begin
        drain_results();
        load_grid_regs(probe_rows[i].grid_w, probe_rows[i].grid_h, probe_rows[i].walls);
      end
      issue_cmd(probe_rows[i].cmd, probe_rows[i].typed, probe_rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin w = 64; h = 64; walls = 0; end
        1: begin w = 64; h = 64; walls = 1; end
        2: begin w = 5; h = 4; walls = 0; end
        3: begin w = 2; h = 2; walls = 0; end
        4: begin w = 127; h = 1; walls = 1; end
        5: begin w = 0; h = 127; walls = 0; end
        default: begin
          w = 7'($urandom_range(127));
          h = 7'($urandom_range(127));
          walls = 1'($urandom);
        end
      endcase
      drain_results();
      load_grid_regs(w, h, walls);
      idle_on = (p != 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 2 && n == ITEMS_PER_PHASE / 2) drain_results();
        if (idle_on && $urandom_range(99) < 10) idle_cycles($urandom_range(1, 5));
        issue_cmd(random_cmd(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
